>>> hw/rtl/lrs_pkg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Linear range scaler package
// Shared types, register codes and sizing constants for the range scaler.
// ----------------------------------------------------------------------------
package lrs_pkg;

  localparam int unsigned DataW    = 32;
  localparam int unsigned DzW      = 13;
  localparam int unsigned AddrW    = 5;
  localparam int unsigned JobqDepth = 2;
  localparam int unsigned JobqAw   = $clog2(JobqDepth);
  localparam int unsigned DivSteps = 32;
  localparam int unsigned DivCw    = $clog2(DivSteps);

  // Reset values of the range registers.
  localparam logic [DataW-1:0] InMaxReset  = DataW'(255);
  localparam logic [DataW-1:0] OutMaxReset = DataW'(255);

  typedef enum logic [2:0] {
    REG_IN_MIN    = 3'd0,
    REG_IN_MAX    = 3'd1,
    REG_OUT_MIN   = 3'd2,
    REG_OUT_MAX   = 3'd3,
    REG_DEAD_ZONE = 3'd4
  } reg_idx_e;

  typedef enum logic {
    FUNC_PUSH   = 1'b0,
    FUNC_ENABLE = 1'b1
  } func_e;

  typedef enum logic [2:0] {
    BK_IDLE,
    BK_MUL,
    BK_RND,
    BK_DIV,
    BK_POST
  } back_state_e;

  typedef struct packed {
    logic signed [DataW-1:0] in_min;
    logic signed [DataW-1:0] in_max;
    logic signed [DataW-1:0] out_min;
    logic signed [DataW-1:0] out_max;
    logic [DzW-1:0]          dead_zone;
  } lrs_cfg_t;

  // One scaling job: clamped input less in_min, as a 33-bit signed offset.
  typedef struct packed {
    logic signed [DataW:0] dx;
  } lrs_job_t;

endpackage

>>> hw/rtl/lrs_front.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Range scaler front end
// Accepts items, applies enable items and clamps values to the input range.
// ----------------------------------------------------------------------------
module lrs_front import lrs_pkg::*; (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              push,
  output logic              full,
  input  logic              func_i,
  input  logic [DataW-1:0]  value_i,
  input  lrs_cfg_t          cfg_i,
  input  logic              q_full_i,
  output logic              q_wr_o,
  output lrs_job_t          q_job_o
);

  logic                    enabled_q, enabled_d;
  logic                    accept;
  logic signed [DataW-1:0] v_s;
  logic signed [DataW-1:0] lo, hi, v_c;

  assign full   = q_full_i;
  assign accept = push && !q_full_i;
  assign v_s    = $signed(value_i);

  always_comb begin
    enabled_d = enabled_q;
    if (accept && func_e'(func_i) == FUNC_ENABLE) begin
      enabled_d = (value_i != '0);
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      enabled_q <= 1'b1;
    end else begin
      enabled_q <= enabled_d;
    end
  end

  always_comb begin
    lo  = (cfg_i.in_min < cfg_i.in_max) ? cfg_i.in_min : cfg_i.in_max;
    hi  = (cfg_i.in_min < cfg_i.in_max) ? cfg_i.in_max : cfg_i.in_min;
    v_c = v_s;
    if (v_s < lo) begin
      v_c = lo;
    end
    if (v_s > hi) begin
      v_c = hi;
    end
    q_job_o.dx = {v_c[DataW-1], v_c} - {cfg_i.in_min[DataW-1], cfg_i.in_min};
  end

  assign q_wr_o = accept && func_e'(func_i) == FUNC_PUSH && enabled_q;

endmodule

>>> hw/rtl/lrs_jobq.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Range scaler job queue
// Short first-in first-out queue between the front end and the arithmetic.
// ----------------------------------------------------------------------------
module lrs_jobq import lrs_pkg::*; (
  input  logic     clk_i,
  input  logic     rst_ni,
  input  logic     wr_i,
  input  lrs_job_t wr_data_i,
  output logic     full_o,
  input  logic     rd_i,
  output lrs_job_t rd_data_o,
  output logic     empty_o
);

  lrs_job_t            mem_q [JobqDepth];
  logic [JobqAw-1:0]   wr_ptr_q, rd_ptr_q;
  logic [JobqAw:0]     count_q;
  logic                do_wr, do_rd;

  assign full_o    = (count_q == (JobqAw+1)'(JobqDepth));
  assign empty_o   = (count_q == '0);
  assign do_wr     = wr_i && !full_o;
  assign do_rd     = rd_i && !empty_o;
  assign rd_data_o = mem_q[rd_ptr_q];

  always_ff @(posedge clk_i) begin
    if (do_wr) begin
      mem_q[wr_ptr_q] <= wr_data_i;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= '0;
      rd_ptr_q <= '0;
      count_q  <= '0;
    end else begin
      if (do_wr) begin
        wr_ptr_q <= wr_ptr_q + JobqAw'(1);
      end
      if (do_rd) begin
        rd_ptr_q <= rd_ptr_q + JobqAw'(1);
      end
      if (do_wr && !do_rd) begin
        count_q <= count_q + (JobqAw+1)'(1);
      end else if (do_rd && !do_wr) begin
        count_q <= count_q - (JobqAw+1)'(1);
      end
    end
  end

endmodule

>>> hw/rtl/lrs_back.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Range scaler back end
// Multiplies, divides with rounding, offsets, clamps and applies the dead zone.
// ----------------------------------------------------------------------------
module lrs_back import lrs_pkg::*; (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  lrs_cfg_t          cfg_i,
  input  logic              job_valid_i,
  input  lrs_job_t          job_i,
  output logic              job_pop_o,
  input  logic              pop,
  output logic              empty,
  output logic [DataW-1:0]  result_o
);

  back_state_e             state_q, state_d;
  logic signed [DataW:0]   dx_q;
  logic [2*DataW-1:0]      prod_q;
  logic [DataW-1:0]        rem_q;
  logic [DataW-1:0]        quo_q;
  logic [DivCw-1:0]        cnt_q;
  logic                    neg_q;
  logic                    out_valid_q;
  logic [DataW-1:0]        result_q;

  logic signed [DataW:0]   span_s, dy_s, dx_neg;
  logic                    span_neg, dy_neg, span_zero;
  logic [DataW-1:0]        den, dy_mag, dx_mag;
  logic [2*DataW-1:0]      prod_w;
  logic [2*DataW:0]        rnd_sum;
  logic [DataW:0]          rem_sh, rem_diff;
  logic                    ge;
  logic signed [DataW+1:0] sq, sum34, olo34, ohi34;
  logic signed [DataW-1:0] olo, ohi, clamped;
  logic [DataW:0]          mag;
  logic [DataW-1:0]        final_w;
  logic                    slot_free, load_out;

  // Spans follow the registers; the user must keep them static while busy (unchecked).
  always_comb begin
    span_s    = {cfg_i.in_max[DataW-1], cfg_i.in_max} - {cfg_i.in_min[DataW-1], cfg_i.in_min};
    dy_s      = {cfg_i.out_max[DataW-1], cfg_i.out_max}
              - {cfg_i.out_min[DataW-1], cfg_i.out_min};
    span_neg  = span_s[DataW];
    dy_neg    = dy_s[DataW];
    span_zero = (span_s == '0);
    den       = span_neg ? DataW'(-span_s) : span_s[DataW-1:0];
    dy_mag    = dy_neg ? DataW'(-dy_s) : dy_s[DataW-1:0];
    dx_neg    = -dx_q;
    dx_mag    = dx_q[DataW] ? dx_neg[DataW-1:0] : dx_q[DataW-1:0];
    prod_w    = dx_mag * dy_mag;
    rnd_sum   = {1'b0, prod_q} + (2*DataW+1)'(den >> 1);
    rem_sh    = {rem_q, quo_q[DataW-1]};
    ge        = (rem_sh >= {1'b0, den});
    rem_diff  = rem_sh - {1'b0, den};
  end

  // Offset, clamp to the output range and dead zone; an empty input span gives out_min.
  always_comb begin
    olo     = (cfg_i.out_min < cfg_i.out_max) ? cfg_i.out_min : cfg_i.out_max;
    ohi     = (cfg_i.out_min < cfg_i.out_max) ? cfg_i.out_max : cfg_i.out_min;
    olo34   = (DataW+2)'(olo);
    ohi34   = (DataW+2)'(ohi);
    sq      = neg_q ? -$signed({2'b00, quo_q}) : $signed({2'b00, quo_q});
    sum34   = (DataW+2)'(cfg_i.out_min) + sq;
    if (sum34 < olo34) begin
      clamped = olo;
    end else if (sum34 > ohi34) begin
      clamped = ohi;
    end else begin
      clamped = sum34[DataW-1:0];
    end
    mag     = clamped[DataW-1] ? -{clamped[DataW-1], clamped} : {clamped[DataW-1], clamped};
    final_w = (mag < (DataW+1)'(cfg_i.dead_zone)) ? '0 : clamped;
    if (span_zero) begin
      final_w = cfg_i.out_min;
    end
  end

  assign slot_free = !out_valid_q || pop;

  always_comb begin
    state_d   = state_q;
    job_pop_o = 1'b0;
    load_out  = 1'b0;
    unique case (state_q)
      BK_IDLE: begin
        if (job_valid_i) begin
          job_pop_o = 1'b1;
          state_d   = BK_MUL;
        end
      end
      BK_MUL:  state_d = span_zero ? BK_POST : BK_RND;
      BK_RND:  state_d = BK_DIV;
      BK_DIV: begin
        if (cnt_q == '0) begin
          state_d = BK_POST;
        end
      end
      BK_POST: begin
        if (slot_free) begin
          load_out = 1'b1;
          state_d  = BK_IDLE;
        end
      end
      default: state_d = BK_IDLE;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= BK_IDLE;
      out_valid_q <= 1'b0;
    end else begin
      state_q <= state_d;
      if (load_out) begin
        out_valid_q <= 1'b1;
      end else if (pop) begin
        out_valid_q <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    case (state_q)
      BK_IDLE: begin
        if (job_valid_i) begin
          dx_q <= job_i.dx;
        end
      end
      BK_MUL: begin
        prod_q <= prod_w;
        neg_q  <= dx_q[DataW] ^ dy_neg ^ span_neg;
        quo_q  <= '0;
      end
      BK_RND: begin
        // The rounded quotient stays below 2^32, so the top dividend bits
        // already sit below the divisor.
        rem_q <= rnd_sum[2*DataW-1:DataW];
        quo_q <= rnd_sum[DataW-1:0];
        cnt_q <= DivCw'(DivSteps - 1);
      end
      BK_DIV: begin
        rem_q <= ge ? rem_diff[DataW-1:0] : rem_sh[DataW-1:0];
        quo_q <= {quo_q[DataW-2:0], ge};
        cnt_q <= cnt_q - DivCw'(1);
      end
      default: ;
    endcase
    if (load_out) begin
      result_q <= final_w;
    end
  end

  assign empty    = !out_valid_q;
  assign result_o = result_q;

  // The partial remainder always stays below the divisor.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    state_q == BK_DIV |-> rem_q < den)
    else $error("divider remainder not below span");

  // A rounded quotient never exceeds the output span.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == BK_POST && !span_zero) |-> quo_q <= dy_mag)
    else $error("quotient exceeds output span");

  // A waiting result is neither lost nor altered until it is taken.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid_q && !pop) |=> (out_valid_q && $stable(result_q)))
    else $error("waiting result dropped or changed");

  // A job is taken from the queue only when one is there.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    job_pop_o |=> state_q == BK_MUL && $past(job_valid_i))
    else $error("job popped from empty queue");

endmodule

>>> hw/rtl/linear_range_scaler_top.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Linear range scaler
// Maps a signed value from a configured input range onto an output range.
// ----------------------------------------------------------------------------
// Usage
//   Items enter through a queue-like port: an item is taken when push is high
//   and full is low. An item with func_i set loads the enable flag from
//   value_i (nonzero enables) and yields no result; a push item while
//   disabled is dropped. Every other push item yields one result item.
//   Results leave through a queue-like port: result_o holds the oldest item
//   while empty is low, and it is taken when pop is high.
//   The front end clamps the value and places a job in a two-entry queue.
//   The back end takes one job at a time and steps through loading it, the
//   32 by 32 bit product, the rounding add, the bit-serial restoring divider
//   and a final step that offsets, clamps and applies the dead zone; it takes
//   no new job until its result has gone to the output register. An empty
//   input span skips the rounding add and the divider.
//   While the receiver stalls, the finished result waits in the output
//   register and the back end holds its next result; the front end keeps
//   taking items until the job queue is full.
//   Reset empties both queues, enables the block and loads the register
//   reset values. The range registers are written over the APB-style port
//   at byte addresses 0, 4, 8, 12 and 16; the user must write them only
//   while the block is idle, which the block itself does not enforce.
// ----------------------------------------------------------------------------
module linear_range_scaler_top import lrs_pkg::*; (
  input  logic              clk_i,
  input  logic              rst_ni,
  // item input
  input  logic              push,
  output logic              full,
  input  logic              func_i,
  input  logic [DataW-1:0]  value_i,
  // result output
  output logic              empty,
  input  logic              pop,
  output logic [DataW-1:0]  result_o,
  // configuration
  input  logic              psel,
  input  logic              penable,
  input  logic              pwrite,
  input  logic [AddrW-1:0]  paddr,
  input  logic [DataW-1:0]  pwdata,
  output logic [DataW-1:0]  prdata,
  output logic              pready
);

  lrs_cfg_t  cfg_q;
  reg_idx_e  reg_idx;
  logic      cfg_wr;
  logic      q_full, q_wr, q_empty, q_rd;
  lrs_job_t  q_wr_job, q_rd_job;

  // Configuration registers. Writes to addresses past the register list fall
  // through to the default arm and are ignored.
  assign pready  = 1'b1;
  assign reg_idx = reg_idx_e'(paddr[AddrW-1:2]);
  assign cfg_wr  = psel && penable && pwrite && pready;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_q.in_min    <= '0;
      cfg_q.in_max    <= InMaxReset;
      cfg_q.out_min   <= '0;
      cfg_q.out_max   <= OutMaxReset;
      cfg_q.dead_zone <= '0;
    end else if (cfg_wr) begin
      unique case (reg_idx)
        REG_IN_MIN:    cfg_q.in_min    <= pwdata;
        REG_IN_MAX:    cfg_q.in_max    <= pwdata;
        REG_OUT_MIN:   cfg_q.out_min   <= pwdata;
        REG_OUT_MAX:   cfg_q.out_max   <= pwdata;
        REG_DEAD_ZONE: cfg_q.dead_zone <= pwdata[DzW-1:0];
        default: ;
      endcase
    end
  end

  // Register read-back; unused addresses read as zero.
  always_comb begin
    unique case (reg_idx)
      REG_IN_MIN:    prdata = cfg_q.in_min;
      REG_IN_MAX:    prdata = cfg_q.in_max;
      REG_OUT_MIN:   prdata = cfg_q.out_min;
      REG_OUT_MAX:   prdata = cfg_q.out_max;
      REG_DEAD_ZONE: prdata = DataW'(cfg_q.dead_zone);
      default:       prdata = '0;
    endcase
  end

  // Front end: takes items, tracks the enable flag and clamps the value.
  lrs_front u_front (
    .clk_i    (clk_i),
    .rst_ni   (rst_ni),
    .push     (push),
    .full     (full),
    .func_i   (func_i),
    .value_i  (value_i),
    .cfg_i    (cfg_q),
    .q_full_i (q_full),
    .q_wr_o   (q_wr),
    .q_job_o  (q_wr_job)
  );

  // Job queue between the two halves, so each can stall on its own.
  lrs_jobq u_jobq (
    .clk_i     (clk_i),
    .rst_ni    (rst_ni),
    .wr_i      (q_wr),
    .wr_data_i (q_wr_job),
    .full_o    (q_full),
    .rd_i      (q_rd),
    .rd_data_o (q_rd_job),
    .empty_o   (q_empty)
  );

  // Back end: multiply, divide with rounding, offset, clamp and dead zone.
  lrs_back u_back (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cfg_i       (cfg_q),
    .job_valid_i (!q_empty),
    .job_i       (q_rd_job),
    .job_pop_o   (q_rd),
    .pop         (pop),
    .empty       (empty),
    .result_o    (result_o)
  );

endmodule

>>> verif/lrs_checker.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Range scaler checker
// Watches the item, result and register ports of the range scaler. It keeps
// its own copy of the registers and the enable flag, predicts each result,
// compares the results in order of arrival and checks register reads.
// ----------------------------------------------------------------------------
module lrs_checker import lrs_pkg::*; (
  input  logic             clk_i,
  input  logic             rst_ni,
  input  logic             push_i,
  input  logic             full_i,
  input  logic             func_i,
  input  logic [DataW-1:0] value_i,
  input  logic             empty_i,
  input  logic             pop_i,
  input  logic [DataW-1:0] result_i,
  input  logic             psel_i,
  input  logic             penable_i,
  input  logic             pwrite_i,
  input  logic [AddrW-1:0] paddr_i,
  input  logic [DataW-1:0] pwdata_i,
  input  logic [DataW-1:0] prdata_i,
  input  logic             pready_i,
  output int               errors_o,
  output int               pending_o
);

  typedef bit [63:0] mag_t;

  localparam int unsigned ReportLimit = 10;

  lrs_cfg_t         cfg_copy;
  logic             enabled_copy;
  logic [DataW-1:0] scaled_q[$];
  int               mismatches = 0;

  function automatic mag_t magnitude(input longint x);
    return (x < 0) ? mag_t'(-x) : mag_t'(x);
  endfunction

  // Clamp, scale with rounding half away from zero, offset, clamp again and
  // apply the dead zone; an empty input span gives out_min.
  function automatic logic [DataW-1:0] scale_item(input lrs_cfg_t c,
                                                  input logic [DataW-1:0] raw);
    logic signed [DataW-1:0] imn = c.in_min;
    logic signed [DataW-1:0] imx = c.in_max;
    logic signed [DataW-1:0] omn = c.out_min;
    logic signed [DataW-1:0] omx = c.out_max;
    logic signed [DataW-1:0] v   = raw;
    logic signed [DataW-1:0] lo, hi, olo, ohi;
    longint span, dx, dy, sq, res, res_mag;
    mag_t   num, den, q;
    logic   negate;
    lo  = (imn < imx) ? imn : imx;
    hi  = (imn < imx) ? imx : imn;
    olo = (omn < omx) ? omn : omx;
    ohi = (omn < omx) ? omx : omn;
    if (v < lo) v = lo;
    if (v > hi) v = hi;
    span = longint'(imx) - longint'(imn);
    if (span == 0) return omn;
    dx = longint'(v) - longint'(imn);
    dy = longint'(omx) - longint'(omn);
    negate = ((dx < 0) != (dy < 0)) && (dx != 0) && (dy != 0);
    negate = negate != (span < 0);
    num = magnitude(dx) * magnitude(dy);
    den = magnitude(span);
    q   = (num + den / 2) / den;
    sq  = longint'(q);
    if (negate) sq = -sq;
    res = longint'(omn) + sq;
    if (res < longint'(olo)) res = longint'(olo);
    if (res > longint'(ohi)) res = longint'(ohi);
    res_mag = (res < 0) ? -res : res;
    if (res_mag < longint'(c.dead_zone)) res = 0;
    return res[DataW-1:0];
  endfunction

  function automatic logic [DataW-1:0] reg_value(input lrs_cfg_t c,
                                                 input logic [2:0] idx);
    case (idx)
      REG_IN_MIN:  return c.in_min;
      REG_IN_MAX:  return c.in_max;
      REG_OUT_MIN: return c.out_min;
      REG_OUT_MAX: return c.out_max;
      default:     return DataW'(c.dead_zone);
    endcase
  endfunction

  task automatic note_mismatch(input string what, input logic [DataW-1:0] want,
                               input logic [DataW-1:0] got);
    mismatches++;
    if (mismatches <= ReportLimit)
      $display("%0t: mismatch on %s: expected %h, got %h", $realtime, what, want, got);
  endtask

  always @(posedge clk_i or negedge rst_ni) begin
    logic [DataW-1:0] want;
    logic [2:0]       idx;
    if (!rst_ni) begin
      cfg_copy.in_min    = '0;
      cfg_copy.in_max    = InMaxReset;
      cfg_copy.out_min   = '0;
      cfg_copy.out_max   = OutMaxReset;
      cfg_copy.dead_zone = '0;
      enabled_copy       = 1'b1;
      scaled_q.delete();
    end else begin
      if (pop_i && !empty_i) begin
        if (scaled_q.size() == 0) begin
          note_mismatch("result with none outstanding", '0, result_i);
        end else begin
          want = scaled_q.pop_front();
          if (result_i !== want) note_mismatch("result", want, result_i);
        end
      end
      if (push_i && !full_i) begin
        if (func_i == FUNC_ENABLE) begin
          enabled_copy = (value_i != '0);
        end else if (enabled_copy) begin
          scaled_q.push_back(scale_item(cfg_copy, value_i));
        end
      end
      if (psel_i && penable_i && pready_i) begin
        idx = paddr_i[AddrW-1:2];
        if (pwrite_i) begin
          case (idx)
            REG_IN_MIN:    cfg_copy.in_min    = pwdata_i;
            REG_IN_MAX:    cfg_copy.in_max    = pwdata_i;
            REG_OUT_MIN:   cfg_copy.out_min   = pwdata_i;
            REG_OUT_MAX:   cfg_copy.out_max   = pwdata_i;
            REG_DEAD_ZONE: cfg_copy.dead_zone = pwdata_i[DzW-1:0];
            default: ;
          endcase
        end else if (idx <= REG_DEAD_ZONE) begin
          want = reg_value(cfg_copy, idx);
          if (prdata_i !== want) note_mismatch("register read", want, prdata_i);
        end
      end
    end
    errors_o  <= mismatches;
    pending_o <= scaled_q.size();
  end

endmodule

>>> verif/testbench.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Range scaler testbench
// Drives items and register settings into the range scaler, with a short
// directed part followed by random phases under varying back-pressure. The
// checker beside the block predicts and compares; this module gives the
// verdict.
// ----------------------------------------------------------------------------
module testbench;
  import lrs_pkg::*;

  localparam int ClkPeriod     = 12;
  localparam int ResetCycles   = 3;
  // Settling time that comfortably covers an item still in flight that will
  // not produce a result.
  localparam int IdleSettle    = 60;
  localparam int CycleLimit    = 400000;
  localparam int RandomPhases  = 8;
  localparam int ItemsPerPhase = 100;

  // First register index that maps to nothing; writes there must be ignored.
  localparam logic [2:0] RegFirstUnused = 3'd5;

  localparam logic [DataW-1:0] IntMin    = 32'h8000_0000;
  localparam logic [DataW-1:0] IntMax    = 32'h7FFF_FFFF;
  localparam logic [DataW-1:0] IntMinP1  = 32'h8000_0001;

  logic             clk_i   = 1'b0;
  logic             rst_ni  = 1'b0;
  logic             push    = 1'b0;
  logic             full;
  logic             func_i  = FUNC_PUSH;
  logic [DataW-1:0] value_i = '0;
  logic             empty;
  logic             pop     = 1'b0;
  logic [DataW-1:0] result_o;
  logic             psel    = 1'b0;
  logic             penable = 1'b0;
  logic             pwrite  = 1'b0;
  logic [AddrW-1:0] paddr   = '0;
  logic [DataW-1:0] pwdata  = '0;
  logic [DataW-1:0] prdata;
  logic             pready;

  int errors;
  int pending;

  // Idling percentages for the current phase.
  int send_idle_pct  = 0;
  int recv_stall_pct = 0;

  // The input range as last written, used to aim values at the interesting
  // parts of the range.
  logic signed [DataW-1:0] cur_in_min = '0;
  logic signed [DataW-1:0] cur_in_max = InMaxReset;

  always #(ClkPeriod / 2) clk_i = ~clk_i;

  linear_range_scaler_top dut (
    .clk_i    (clk_i),
    .rst_ni   (rst_ni),
    .push     (push),
    .full     (full),
    .func_i   (func_i),
    .value_i  (value_i),
    .empty    (empty),
    .pop      (pop),
    .result_o (result_o),
    .psel     (psel),
    .penable  (penable),
    .pwrite   (pwrite),
    .paddr    (paddr),
    .pwdata   (pwdata),
    .prdata   (prdata),
    .pready   (pready)
  );

  lrs_checker checker_inst (
    .clk_i     (clk_i),
    .rst_ni    (rst_ni),
    .push_i    (push),
    .full_i    (full),
    .func_i    (func_i),
    .value_i   (value_i),
    .empty_i   (empty),
    .pop_i     (pop),
    .result_i  (result_o),
    .psel_i    (psel),
    .penable_i (penable),
    .pwrite_i  (pwrite),
    .paddr_i   (paddr),
    .pwdata_i  (pwdata),
    .prdata_i  (prdata),
    .pready_i  (pready),
    .errors_o  (errors),
    .pending_o (pending)
  );

  // The receiver decides afresh at every edge whether it will take a result,
  // so stalls land on every phase of the block's work.
  always @(posedge clk_i) begin
    pop <= ($urandom_range(99) >= recv_stall_pct);
  end

  // A hung handshake must not keep the run going for ever.
  initial begin
    repeat (CycleLimit) @(posedge clk_i);
    $display("DONE: errors detected");
    $finish;
  end

  // One register access: a setup phase, then the access phase held until
  // pready, then a pause with the port deselected so that back-to-back
  // accesses never assign psel twice in one step.
  task automatic reg_access(input logic wr, input logic [2:0] idx,
                            input logic [DataW-1:0] data);
    psel    <= 1'b1;
    penable <= 1'b0;
    pwrite  <= wr;
    paddr   <= {idx, 2'b00};
    pwdata  <= data;
    @(posedge clk_i);
    penable <= 1'b1;
    @(posedge clk_i);
    while (!pready) @(posedge clk_i);
    psel    <= 1'b0;
    penable <= 1'b0;
    pwrite  <= 1'b0;
    @(posedge clk_i);
  endtask

  // Stops sending and waits until every outstanding result has been taken,
  // then lets the block finish anything that will not produce a result.
  task automatic wait_idle();
    push <= 1'b0;
    @(posedge clk_i);
    while (pending != 0) @(posedge clk_i);
    repeat (IdleSettle) @(posedge clk_i);
  endtask

  // Registers are only written once the block is idle. Every setting is also
  // followed by a write to an unused index and a read-back of all registers,
  // which shows that the unused write changed nothing.
  task automatic apply_config(input logic [DataW-1:0] imn, input logic [DataW-1:0] imx,
                              input logic [DataW-1:0] omn, input logic [DataW-1:0] omx,
                              input logic [DataW-1:0] dz);
    wait_idle();
    reg_access(1'b1, REG_IN_MIN, imn);
    reg_access(1'b1, REG_IN_MAX, imx);
    reg_access(1'b1, REG_OUT_MIN, omn);
    reg_access(1'b1, REG_OUT_MAX, omx);
    reg_access(1'b1, REG_DEAD_ZONE, dz);
    reg_access(1'b1, RegFirstUnused + 3'($urandom_range(2)), $urandom);
    reg_access(1'b0, REG_IN_MIN, '0);
    reg_access(1'b0, REG_IN_MAX, '0);
    reg_access(1'b0, REG_OUT_MIN, '0);
    reg_access(1'b0, REG_OUT_MAX, '0);
    reg_access(1'b0, REG_DEAD_ZONE, '0);
    cur_in_min = imn;
    cur_in_max = imx;
  endtask

  // Offers one item and returns once it is taken and full is low. Idle
  // cycles come before the item; when there are none, push simply stays
  // high and only the payload changes.
  task automatic send_item(input func_e f, input logic [DataW-1:0] v);
    while (send_idle_pct != 0 && $urandom_range(99) < send_idle_pct) begin
      push <= 1'b0;
      @(posedge clk_i);
    end
    push    <= 1'b1;
    func_i  <= f;
    value_i <= v;
    @(posedge clk_i);
    while (full) @(posedge clk_i);
  endtask

  // Values to scale: a fair share of arbitrary words, the rest inside the
  // current input range, on and just beyond its ends, where clamping acts, or at the extreme words.
  function automatic logic [DataW-1:0] pick_value();
    logic signed [DataW-1:0] lo, hi;
    lo = (cur_in_min < cur_in_max) ? cur_in_min : cur_in_max;
    hi = (cur_in_min < cur_in_max) ? cur_in_max : cur_in_min;
    case ($urandom_range(9))
      0, 1, 2:    return $urandom;
      3, 4, 5, 6: return lo + $urandom_range($unsigned(hi - lo));
      7:          return lo;
      8:          return hi;
      default: begin
        case ($urandom_range(3))
          0:       return lo - 1;
          1:       return hi + 1;
          2:       return IntMin;
          default: return IntMax;
        endcase
      end
    endcase
  endfunction

  function automatic logic [DataW-1:0] pick_extreme();
    case ($urandom_range(4))
      0:       return IntMin;
      1:       return IntMax;
      2:       return IntMinP1;
      3:       return '0;
      default: return 32'd1;
    endcase
  endfunction

  function automatic logic [DataW-1:0] pick_small();
    return DataW'($urandom_range(2000)) - 32'd1000;
  endfunction

  // A random setting: wide arbitrary ranges, small ranges, ranges built from
  // the extreme words, or an empty input span. Either range may come out
  // inverted. The dead zone is off half the time, sometimes in its stated range and
  // sometimes a full word of which only the low bits count.
  task automatic random_config();
    logic [DataW-1:0] r[4];
    logic [DataW-1:0] dz;
    case ($urandom_range(4))
      0: for (int i = 0; i < 4; i++) r[i] = $urandom;
      1, 2: for (int i = 0; i < 4; i++) r[i] = pick_small();
      3: for (int i = 0; i < 4; i++) r[i] = pick_extreme();
      default: begin
        r[0] = pick_small();
        r[1] = r[0];
        r[2] = $urandom;
        r[3] = $urandom;
      end
    endcase
    case ($urandom_range(3))
      0, 1:    dz = '0;
      2:       dz = DataW'($urandom_range(4096));
      default: dz = $urandom;
    endcase
    apply_config(r[0], r[1], r[2], r[3], dz);
  endtask

  initial begin
    repeat (ResetCycles) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    // Reset setting: both ranges 0 to 255. Ends, midpoint and clamping on
    // both sides, then the enable flag: a push while disabled is dropped,
    // and any nonzero word, even one with only the sign bit, enables.
    send_item(FUNC_PUSH, 32'd0);
    send_item(FUNC_PUSH, 32'd255);
    send_item(FUNC_PUSH, 32'd128);
    send_item(FUNC_PUSH, 32'hFFFF_FFFB);
    send_item(FUNC_PUSH, IntMax);
    send_item(FUNC_PUSH, IntMin);
    send_item(FUNC_ENABLE, 32'd0);
    send_item(FUNC_PUSH, 32'd7);
    send_item(FUNC_ENABLE, IntMin);
    send_item(FUNC_PUSH, 32'd7);

    // Exact halves, negative direction: the half must round away from zero.
    apply_config(32'd0, 32'd2, 32'd0, 32'hFFFF_FFFF, 32'd0);
    send_item(FUNC_PUSH, 32'd1);
    send_item(FUNC_PUSH, 32'd2);

    // Widest input range onto the widest inverted output range, with the
    // largest dead zone the register holds.
    apply_config(IntMin, IntMax, IntMax, IntMin, 32'd8191);
    send_item(FUNC_PUSH, 32'd0);
    send_item(FUNC_PUSH, IntMin);
    send_item(FUNC_PUSH, IntMax);
    send_item(FUNC_PUSH, 32'd1);

    // Empty input span: the result is out_min, neither clamped nor zeroed
    // by the dead zone.
    apply_config(32'd1000, 32'd1000, 32'hFFFF_FFFD, 32'd9, 32'd4096);
    send_item(FUNC_PUSH, 32'd5);
    send_item(FUNC_PUSH, 32'd1000);

    // Inverted input range with a small dead zone.
    apply_config(32'd100, 32'hFFFF_FF9C, 32'hFFFF_FFCE, 32'd50, 32'd10);
    send_item(FUNC_PUSH, 32'd0);
    send_item(FUNC_PUSH, 32'd99);
    send_item(FUNC_PUSH, 32'hFFFF_FF9C);
    send_item(FUNC_PUSH, 32'd200);

    // Random phases, each with its own setting and idling pattern. Enable
    // items are sprinkled in, about a third of them disabling the block.
    for (int ph = 0; ph < RandomPhases; ph++) begin
      random_config();
      case (ph % 4)
        0: begin send_idle_pct = 0;  recv_stall_pct = 0;  end
        1: begin send_idle_pct = 82; recv_stall_pct = 0;  end
        2: begin send_idle_pct = 0;  recv_stall_pct = 82; end
        default: begin send_idle_pct = 20; recv_stall_pct = 20; end
      endcase
      send_item(FUNC_ENABLE, $urandom | 32'd1);
      repeat (ItemsPerPhase) begin
        if ($urandom_range(19) == 0)
          send_item(FUNC_ENABLE, ($urandom_range(2) == 0) ? '0 : $urandom);
        else
          send_item(FUNC_PUSH, pick_value());
      end
    end

    wait_idle();
    if (errors == 0)
      $display("DONE: 0 errors");
    else
      $display("DONE: errors detected");
    $finish;
  end

endmodule

>>> linear_range_scaler_top.f
hw/rtl/lrs_pkg.sv
hw/rtl/lrs_front.sv
hw/rtl/lrs_jobq.sv
hw/rtl/lrs_back.sv
hw/rtl/linear_range_scaler_top.sv
verif/lrs_checker.sv
verif/testbench.sv
